/* hdl/websocket_frame_deframer_defines.svh */
// ----------------------------------------------------------------------------
// WebSocket frame deframer assertion macros
// Shared macros that wrap concurrent assertions on the block's clock.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define WSDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define WSDF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Item types, parse phases and header constants of the deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // One byte of a received buffer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_item;

    // One result of the deframer.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic [1:0]  status;
        logic        last;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [31:0] decoded_len;
        logic [32:0] frame_bytes;
    } t_out_item;

    // Parse phase of the frame at the start of the buffer.
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    // Result status codes.
    localparam logic [1:0] STATUS_RUN   = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    // Seven-bit length codes that select an extended length field.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header lengths in bytes, without the mask key.
    localparam logic [3:0] HDR_LEN_BASE  = 4'd2;
    localparam logic [3:0] HDR_LEN_EXT16 = 4'd4;
    localparam logic [3:0] HDR_LEN_EXT64 = 4'd10;
    localparam logic [3:0] MASK_KEY_LEN  = 4'd4;

endpackage

/* hdl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses the frame at the start of a received buffer and unmasks its payload.
// ----------------------------------------------------------------------------
// Usage
// The input channel carries one byte of a received buffer per item, with
// buffer_end set on the final byte. The frame at the start of the buffer is
// parsed: header bytes produce no result, each payload byte produces one
// unmasked result item, and the last payload byte is marked complete with
// the frame size. A zero-length frame completes on its final header byte.
// If the buffer ends before the frame is complete, one item with the
// incomplete status closes the run. Bytes after the frame produce nothing.
// An accepted item waits in the input register, is parsed from there, and
// its result is registered into the output register, which offers it on
// the output channel. Throughput: one item per cycle while the receiver
// takes the results, since the whole state update of the parser is a
// single registered step.
// When the receiver stalls, the result waits in the output register while
// one further item is taken into the input register; ready then falls
// until the output item is taken. Reset empties both registers and puts
// the parser back to expecting the first header byte of a buffer.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wsdf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wsdf_pkg::t_out_item  o_out_data
);
    import wsdf_pkg::*;

    // Input register and output register.
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    // Parser state.
    t_phase      r_phase,         n_phase;
    logic [3:0]  r_header_count,  n_header_count;
    logic [31:0] r_length,        n_length;
    logic [31:0] r_mask_key,      n_mask_key;
    logic        r_mask_flag,     n_mask_flag;
    logic        r_fin,           n_fin;
    logic [3:0]  r_opcode,        n_opcode;
    logic [31:0] r_payload_count, n_payload_count;
    logic [3:0]  r_header_len,    n_header_len;

    // Step results of the byte in the input register.
    t_phase      step_phase;
    logic        step_complete;
    logic        step_carry;
    logic [7:0]  step_pbyte;
    logic [6:0]  len7;
    logic [7:0]  key_byte;
    logic        step_emit;
    logic        length_known;
    t_out_item   result;

    logic        stage_advance;
    logic        proc_fire;

    // The parse stage moves whenever the output register is free or being
    // emptied; a byte that causes no result simply retires.
    assign stage_advance = !r_out_valid || i_out_ready;
    assign proc_fire     = r_in_valid && stage_advance;
    assign o_in_ready    = !r_in_valid || stage_advance;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out;

    // Next state of the parser.
    always_comb begin
        step_phase      = r_phase;
        n_header_count  = r_header_count;
        n_length        = r_length;
        n_mask_key      = r_mask_key;
        n_mask_flag     = r_mask_flag;
        n_fin           = r_fin;
        n_opcode        = r_opcode;
        n_payload_count = r_payload_count;
        n_header_len    = r_header_len;
        step_complete   = 1'b0;
        step_carry      = 1'b0;
        step_pbyte      = 8'd0;
        len7            = r_in.data_byte[6:0];
        key_byte        = 8'd0;

        case (r_phase)
            PH_HDR0: begin
                n_fin           = r_in.data_byte[7];
                n_opcode        = r_in.data_byte[3:0];
                n_mask_flag     = 1'b0;
                n_length        = 32'd0;
                n_mask_key      = 32'd0;
                n_payload_count = 32'd0;
                n_header_count  = 4'd1;
                n_header_len    = HDR_LEN_BASE;
                step_phase      = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask_flag    = r_in.data_byte[7];
                n_header_count = 4'd2;
                if (len7 inside {LEN_EXT16, LEN_EXT64}) begin
                    n_header_len = ((len7 == LEN_EXT16) ? HDR_LEN_EXT16 : HDR_LEN_EXT64)
                                 + (r_in.data_byte[7] ? MASK_KEY_LEN : 4'd0);
                    n_length     = 32'd0;
                    step_phase   = PH_EXTLEN;
                end else begin
                    n_header_len = HDR_LEN_BASE + (r_in.data_byte[7] ? MASK_KEY_LEN : 4'd0);
                    n_length     = {25'd0, len7};
                    if (r_in.data_byte[7]) begin
                        step_phase = PH_MASK;
                    end else if (len7 == 7'd0) begin
                        step_phase    = PH_DONE;
                        step_complete = 1'b1;
                    end else begin
                        step_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                // A 64-bit length keeps only its low 32 bits by shifting through.
                n_length       = {r_length[23:0], r_in.data_byte};
                n_header_count = r_header_count + 4'd1;
                if (n_header_count == (r_mask_flag ? r_header_len - MASK_KEY_LEN
                                                   : r_header_len)) begin
                    if (r_mask_flag) begin
                        step_phase = PH_MASK;
                    end else if (n_length == 32'd0) begin
                        step_phase    = PH_DONE;
                        step_complete = 1'b1;
                    end else begin
                        step_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_MASK: begin
                n_mask_key     = {r_mask_key[23:0], r_in.data_byte};
                n_header_count = r_header_count + 4'd1;
                if (n_header_count == r_header_len) begin
                    if (r_length == 32'd0) begin
                        step_phase    = PH_DONE;
                        step_complete = 1'b1;
                    end else begin
                        step_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                case (r_payload_count[1:0])
                    2'd0:    key_byte = r_mask_key[31:24];
                    2'd1:    key_byte = r_mask_key[23:16];
                    2'd2:    key_byte = r_mask_key[15:8];
                    default: key_byte = r_mask_key[7:0];
                endcase
                step_pbyte      = r_in.data_byte ^ (r_mask_flag ? key_byte : 8'd0);
                step_carry      = 1'b1;
                n_payload_count = r_payload_count + 32'd1;
                if (n_payload_count == r_length) begin
                    step_phase    = PH_DONE;
                    step_complete = 1'b1;
                end
            end
            default: begin
                // Bytes after the frame are ignored.
            end
        endcase

        // Any buffer end returns the parser to the first header byte.
        n_phase = r_in.buffer_end ? PH_HDR0 : step_phase;
    end

    // Result of the byte in the input register.
    always_comb begin
        length_known = (step_phase == PH_MASK) || (step_phase == PH_PAYLOAD)
                    || (step_phase == PH_DONE);
        step_emit    = step_complete || step_carry
                    || (r_in.buffer_end && (r_phase != PH_DONE));

        result.is_payload = step_carry && (step_complete || !r_in.buffer_end);
        result.payload_byte = result.is_payload ? step_pbyte : 8'd0;
        if (step_complete) begin
            result.status = STATUS_DONE;
        end else if (r_in.buffer_end) begin
            result.status = STATUS_SHORT;
        end else begin
            result.status = STATUS_RUN;
        end
        result.last        = (result.status != STATUS_RUN);
        result.fin         = n_fin;
        result.opcode      = n_opcode;
        result.masked      = n_mask_flag;
        result.decoded_len = length_known ? n_length : 32'd0;
        result.frame_bytes = step_complete ? ({29'd0, n_header_len} + {1'b0, n_length})
                                           : 33'd0;
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= PH_HDR0;
            r_header_count  <= 4'd0;
            r_length        <= 32'd0;
            r_mask_key      <= 32'd0;
            r_mask_flag     <= 1'b0;
            r_fin           <= 1'b0;
            r_opcode        <= 4'd0;
            r_payload_count <= 32'd0;
            r_header_len    <= HDR_LEN_BASE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (stage_advance) begin
                r_out_valid <= proc_fire && step_emit;
            end
            if (proc_fire) begin
                r_phase         <= n_phase;
                r_header_count  <= n_header_count;
                r_length        <= n_length;
                r_mask_key      <= n_mask_key;
                r_mask_flag     <= n_mask_flag;
                r_fin           <= n_fin;
                r_opcode        <= n_opcode;
                r_payload_count <= n_payload_count;
                r_header_len    <= n_header_len;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (stage_advance) begin
            r_out <= result;
        end
    end

    // Assertions.
    `WSDF_ASSERT(a_last_matches_status,
        r_out_valid |-> (r_out.last == (r_out.status != STATUS_RUN)),
        "last flag disagrees with status")
    `WSDF_ASSERT(a_no_payload_when_short,
        (r_out_valid && r_out.is_payload) |-> (r_out.status != STATUS_SHORT),
        "payload byte carried on an incomplete result")
    `WSDF_ASSERT(a_buffer_end_rewinds,
        (proc_fire && r_in.buffer_end) |=> (r_phase == PH_HDR0),
        "parser not rewound after buffer end")
    `WSDF_ASSERT(a_payload_count_bound,
        (r_phase == PH_PAYLOAD) |-> (r_payload_count < r_length),
        "payload count reached length inside payload phase")
    `WSDF_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> (!r_in_valid && !r_out_valid),
        "registers not emptied by reset")

endmodule

/* dv/tb_websocket_frame_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives received buffers byte by byte and checks every result item against
// a cycle-free model of the parser. Buffers are whole frames, cut frames and
// noise. Both channels idle and stall at random, and the receiver holds off
// for a long stretch once.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    import wsdf_pkg::*;

    // How the payload length of a generated frame is encoded.
    typedef enum int {
        LEN_FORM_7,
        LEN_FORM_16,
        LEN_FORM_64
    } t_len_form;

    typedef logic [7:0] t_byte_q[$];

    localparam int unsigned RX_HOLD_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned ITEMS_PER_PHASE = 217;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the parser state, predicts the result
    // of every accepted byte and checks the results in order.
    // ------------------------------------------------------------------------
    class deframe_scoreboard;
        t_phase      phase;
        logic [3:0]  hdr_count;
        logic [3:0]  hdr_len;
        logic [31:0] frame_len;
        logic [31:0] mask_key;
        logic [31:0] pay_count;
        logic        mask_flag;
        logic        fin_flag;
        logic [3:0]  opcode;
        t_out_item   expected_q[$];
        int unsigned mismatches;

        function new();
            phase      = PH_HDR0;
            hdr_count  = '0;
            hdr_len    = HDR_LEN_BASE;
            frame_len  = '0;
            mask_key   = '0;
            pay_count  = '0;
            mask_flag  = 1'b0;
            fin_flag   = 1'b0;
            opcode     = '0;
            mismatches = 0;
        endfunction

        // A zero-length payload completes the frame on the last header byte.
        function logic open_payload();
            if (frame_len == 0) begin
                phase = PH_DONE;
                return 1'b1;
            end
            phase = PH_PAYLOAD;
            return 1'b0;
        endfunction

        function logic finish_length();
            if (mask_flag) begin
                phase = PH_MASK;
                return 1'b0;
            end
            return open_payload();
        endfunction

        function void note_byte(t_in_item item);
            logic [7:0] b;
            t_phase     start;
            logic       complete;
            logic       carry;
            logic       emit;
            logic       known;
            logic [7:0] pbyte;
            logic [7:0] key_byte;
            logic [1:0] status;
            logic [6:0] len7;
            t_out_item  res;
            b        = item.data_byte;
            start    = phase;
            complete = 1'b0;
            carry    = 1'b0;
            emit     = 1'b0;
            pbyte    = '0;
            status   = STATUS_RUN;
            case (phase)
                PH_HDR0: begin
                    fin_flag  = b[7];
                    opcode    = b[3:0];
                    mask_flag = 1'b0;
                    frame_len = '0;
                    mask_key  = '0;
                    pay_count = '0;
                    hdr_count = 4'd1;
                    hdr_len   = HDR_LEN_BASE;
                    phase     = PH_HDR1;
                end
                PH_HDR1: begin
                    len7      = b[6:0];
                    mask_flag = b[7];
                    hdr_count = 4'd2;
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        hdr_len   = ((len7 == LEN_EXT16) ? HDR_LEN_EXT16 : HDR_LEN_EXT64)
                                  + (mask_flag ? MASK_KEY_LEN : 4'd0);
                        frame_len = '0;
                        phase     = PH_EXTLEN;
                    end else begin
                        hdr_len   = HDR_LEN_BASE + (mask_flag ? MASK_KEY_LEN : 4'd0);
                        frame_len = {25'd0, len7};
                        complete  = finish_length();
                    end
                end
                PH_EXTLEN: begin
                    // Only the low 32 bits of a 64-bit length survive the shift.
                    frame_len = {frame_len[23:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count == hdr_len - (mask_flag ? MASK_KEY_LEN : 4'd0))
                        complete = finish_length();
                end
                PH_MASK: begin
                    mask_key  = {mask_key[23:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count == hdr_len)
                        complete = open_payload();
                end
                PH_PAYLOAD: begin
                    key_byte  = mask_flag ? mask_key[8 * (3 - pay_count[1:0]) +: 8] : 8'd0;
                    pbyte     = b ^ key_byte;
                    carry     = 1'b1;
                    emit      = 1'b1;
                    pay_count = pay_count + 1;
                    if (pay_count == frame_len) begin
                        phase    = PH_DONE;
                        complete = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            known = (phase == PH_MASK || phase == PH_PAYLOAD || phase == PH_DONE);

            // Completion wins over the buffer end; an early end drops the byte.
            if (complete) begin
                emit   = 1'b1;
                status = STATUS_DONE;
            end else if (item.buffer_end && start != PH_DONE) begin
                emit   = 1'b1;
                carry  = 1'b0;
                pbyte  = '0;
                status = STATUS_SHORT;
            end

            if (item.buffer_end)
                phase = PH_HDR0;

            if (emit) begin
                res.payload_byte = carry ? pbyte : 8'd0;
                res.is_payload   = carry;
                res.status       = status;
                res.last         = (status != STATUS_RUN);
                res.fin          = fin_flag;
                res.opcode       = opcode;
                res.masked       = mask_flag;
                res.decoded_len  = known ? frame_len : 32'd0;
                res.frame_bytes  = (status == STATUS_DONE)
                                 ? {29'd0, hdr_len} + {1'b0, frame_len} : 33'd0;
                expected_q.push_back(res);
            end
        endfunction

        function void compare(string field, logic [32:0] want, logic [32:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none, actual 0x%0h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare("payload_byte", want.payload_byte, got.payload_byte);
            compare("is_payload", want.is_payload, got.is_payload);
            compare("status", want.status, got.status);
            compare("last", want.last, got.last);
            compare("fin", want.fin, got.fin);
            compare("opcode", want.opcode, got.opcode);
            compare("masked", want.masked, got.masked);
            compare("decoded_len", want.decoded_len, got.decoded_len);
            compare("frame_bytes", want.frame_bytes, got.frame_bytes);
        endfunction

        function void flag_leftovers();
            while (expected_q.size() != 0) begin
                mismatches++;
                $display("%0t: result expected 0x%0h, actual none", $time, expected_q[0]);
                void'(expected_q.pop_front());
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;

    deframe_scoreboard sb = new();

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          rx_hold_req  = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent   = 0;

    websocket_frame_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The monitor samples both channels at the rising edge, before any of
    // this edge's updates land. The result is checked before the new byte is
    // noted, so that an expectation added at this edge is never consumed by
    // a result that was caused earlier.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready)
                sb.note_byte(i_in_data);
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // The receiver stalls at random. When a hold-off is requested it keeps
    // ready low for a long stretch, counted here, so that the block fills up
    // and has to stall its input while the sender keeps offering items.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------

    // Offers one byte and returns in the step at which it is accepted. An idle
    // gap lowers valid first; without a gap valid simply stays high, so valid
    // is never lowered and raised within the same step.
    task automatic send_byte(input logic [7:0] b, input logic is_end);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_in_item'{data_byte: b, buffer_end: is_end};
        do
            @(posedge i_clk);
        while (!o_in_ready);
    endtask

    // Sends a whole buffer, with the end marker on its final byte.
    task automatic send_buffer(input t_byte_q bytes);
        foreach (bytes[k])
            send_byte(bytes[k], k == bytes.size() - 1);
    endtask

    // Lowers valid and waits until every expected result has arrived. It
    // waits on the clock first, so the caller may drive valid again at once.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    // Builds a frame header followed by npay random payload bytes. For the
    // 64-bit form the upper four length bytes come from ext_hi.
    function automatic t_byte_q make_frame(input logic [7:0] first, input logic mask,
                                           input t_len_form form, input logic [31:0] plen,
                                           input logic [31:0] ext_hi, input int unsigned npay);
        t_byte_q     q;
        logic [31:0] key;
        key = $urandom;
        q.push_back(first);
        case (form)
            LEN_FORM_7: begin
                q.push_back({mask, plen[6:0]});
            end
            LEN_FORM_16: begin
                q.push_back({mask, LEN_EXT16});
                q.push_back(plen[15:8]);
                q.push_back(plen[7:0]);
            end
            default: begin
                q.push_back({mask, LEN_EXT64});
                for (int k = 3; k >= 0; k--)
                    q.push_back(ext_hi[8 * k +: 8]);
                for (int k = 3; k >= 0; k--)
                    q.push_back(plen[8 * k +: 8]);
            end
        endcase
        if (mask)
            for (int k = 3; k >= 0; k--)
                q.push_back(key[8 * k +: 8]);
        repeat (npay)
            q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // One random buffer: mostly whole frames, some cut short, some noise.
    // Trailing bytes after a whole frame are ignored by the block and are
    // not counted towards the items sent.
    task automatic send_random_buffer();
        t_byte_q     q;
        int unsigned kind;
        int unsigned counted;
        int unsigned cut;
        t_len_form   form;
        logic        mask;
        logic [31:0] plen;
        kind = $urandom_range(99);
        form = t_len_form'($urandom_range(2));
        mask = 1'($urandom_range(1));
        if (kind < 70) begin
            plen = ($urandom_range(19) == 0) ? $urandom_range(125) : $urandom_range(12);
            q = make_frame(8'($urandom_range(255)), mask, form, plen, $urandom, plen);
            counted = q.size();
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1))
                    q.push_back(8'($urandom_range(255)));
        end else if (kind < 90) begin
            // Cut frames may claim any length, since the payload never ends.
            plen = $urandom_range(1) ? $urandom : $urandom_range(8);
            if (form == LEN_FORM_7)
                plen = plen % 126;
            else if (form == LEN_FORM_16)
                plen = plen & 32'h0000_FFFF;
            q = make_frame(8'($urandom_range(255)), mask, form, plen, $urandom,
                           (plen > 6) ? 6 : plen);
            cut = $urandom_range(q.size() - 1, 1);
            while (q.size() > cut)
                void'(q.pop_back());
            counted = q.size();
        end else begin
            repeat ($urandom_range(6, 1))
                q.push_back(8'($urandom_range(255)));
            counted = q.size();
        end
        send_buffer(q);
        items_sent += counted;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        t_byte_q q;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct  = 24;
        rx_stall_pct = 66;

        // Directed buffers. A buffer that ends on the first header byte.
        q = '{8'hFF};
        send_buffer(q);
        // A zero-length frame whose header ends together with the buffer.
        q = '{8'h81, 8'h00};
        send_buffer(q);
        // A masked zero-length frame followed by a byte that is ignored.
        q = make_frame(8'h8A, 1'b1, LEN_FORM_7, 32'd0, 32'd0, 0);
        q.push_back(8'hFF);
        send_buffer(q);
        // A 64-bit length whose upper bytes are all ones and are dropped.
        q = make_frame(8'h70, 1'b1, LEN_FORM_64, 32'd1, 32'hFFFF_FFFF, 1);
        send_buffer(q);
        // The largest 16-bit length, cut short inside the payload.
        q = make_frame(8'h82, 1'b0, LEN_FORM_16, 32'h0000_FFFF, 32'd0, 2);
        send_buffer(q);
        pause_until_drained();

        // Random buffers in three phases of idling. At the start of the
        // last one the receiver holds off while the sender runs flat out.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 24;
                    rx_stall_pct = 66;
                end
                1: begin
                    tx_idle_pct  = 66;
                    rx_stall_pct = 24;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    rx_hold_req  = 1'b1;
                end
            endcase
            while (items_sent < (ph + 1) * ITEMS_PER_PHASE)
                send_random_buffer();
            pause_until_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
